[rtl/ehp_pkg.sv]
// ---------------------------------------------------------------------------
// ehp_pkg: shared types and constants for the Ethernet/IP header parser
// Frame record, filter set, result item and the codes used by every stage.
// ---------------------------------------------------------------------------
package ehp_pkg;

    // bytes of the frame head that are kept; later bytes are not captured
    localparam int HEADER_BYTES = 78;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // byte positions in the frame
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_IHL      = 16'd14;
    localparam logic [15:0] POS_NH6      = 16'd20;
    localparam logic [15:0] POS_PROTO4   = 16'd23;
    localparam logic [15:0] POS_PORT6    = 16'd54;
    localparam int          ADDR_FIRST   = 22;
    localparam int          ADDR_BYTES   = 32;
    localparam int          PORT_BYTES   = 4;

    // length thresholds
    localparam logic [15:0] ETH_LEN   = 16'd14;
    localparam logic [15:0] IP4_END   = 16'd34;
    localparam logic [15:0] IP6_END   = 16'd54;
    localparam logic [6:0]  ETH_LEN7  = 7'd14;
    localparam logic [16:0] TCP_MIN   = 17'd20;
    localparam logic [16:0] UDP_MIN   = 17'd8;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // frame class codes
    localparam logic [2:0] CLS_SHORT     = 3'd0;
    localparam logic [2:0] CLS_NON_IP    = 3'd1;
    localparam logic [2:0] CLS_IPV4      = 3'd2;
    localparam logic [2:0] CLS_IPV6      = 3'd3;
    localparam logic [2:0] CLS_IPV4_TRNC = 3'd4;
    localparam logic [2:0] CLS_IPV6_TRNC = 3'd5;

    // transport codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TCP   = 2'd1;
    localparam logic [1:0] KIND_UDP   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // configuration register indexes
    localparam int          CFG_INDEX_W     = 3;
    localparam logic [2:0]  CFG_IS_IPV6     = 3'd0;
    localparam logic [2:0]  CFG_SRC_HIGH    = 3'd1;
    localparam logic [2:0]  CFG_SRC_LOW     = 3'd2;
    localparam logic [2:0]  CFG_DST_HIGH    = 3'd3;
    localparam logic [2:0]  CFG_DST_LOW     = 3'd4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 312;
    localparam int M_TUSER_W = 6;

    // captured header bytes of one frame; addr holds bytes 22..53, byte 22 on top
    typedef struct packed {
        logic [15:0]  etype;
        logic [3:0]   ihl;
        logic [7:0]   nh6;
        logic [7:0]   proto4;
        logic [255:0] addr;
        logic [31:0]  port4;
        logic [31:0]  port6;
        logic [15:0]  len;
    } frame_rec_t;

    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
    } filter_t;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [1:0]  transport_kind;
        logic [63:0] source_address_high;
        logic [63:0] source_address_low;
        logic [63:0] destination_address_high;
        logic [63:0] destination_address_low;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic        ports_valid;
        logic        filter_match;
        logic [15:0] frame_length;
    } result_t;

endpackage

[rtl/ehp_filter_regs.sv]
// ---------------------------------------------------------------------------
// ehp_filter_regs: address filter registers
// Takes register writes from the configuration channel.
// ---------------------------------------------------------------------------
module ehp_filter_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ehp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    output ehp_pkg::filter_t                filter
);
    import ehp_pkg::*;

    filter_t filter_reg;

    assign cfg_ready = 1'b1;
    assign filter    = filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IS_IPV6:  filter_reg.is_ipv6  <= cfg_data[0];
                CFG_SRC_HIGH: filter_reg.src_high <= cfg_data;
                CFG_SRC_LOW:  filter_reg.src_low  <= cfg_data;
                CFG_DST_HIGH: filter_reg.dst_high <= cfg_data;
                CFG_DST_LOW:  filter_reg.dst_low  <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

[rtl/ehp_capture.sv]
// ---------------------------------------------------------------------------
// ehp_capture: byte counter and header field capture
// Picks the needed header bytes out of the byte stream and hands a frame
// record to the decoder on the last byte.
// ---------------------------------------------------------------------------
module ehp_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  rec_valid,
    input  logic                  rec_ready,
    output ehp_pkg::frame_rec_t   rec
);
    import ehp_pkg::*;

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] len_now;
    frame_rec_t  cap_reg;
    frame_rec_t  cap_next;
    frame_rec_t  rec_reg;
    logic        rec_valid_reg;
    logic        accept;
    logic        in_hdr;
    logic [3:0]  ihl_cur;
    logic [6:0]  off4;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    assign in_hdr  = count_reg < 16'(HEADER_BYTES);
    assign len_now = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 16'd1;
    assign ihl_cur = (count_reg == POS_IHL) ? data_byte[3:0] : cap_reg.ihl;
    assign off4    = ETH_LEN7 + {1'b0, ihl_cur, 2'b00};

    always_comb
    begin
        cap_next     = cap_reg;
        cap_next.len = len_now;
        // IPv4 ports of a new frame start from zero so port bytes the frame does not reach read as zero
        if (count_reg == 16'd0)
        begin
            cap_next.port4 = '0;
        end
        if (in_hdr)
        begin
            if (count_reg == POS_ETYPE_HI) cap_next.etype[15:8] = data_byte;
            if (count_reg == POS_ETYPE_LO) cap_next.etype[7:0]  = data_byte;
            if (count_reg == POS_IHL)      cap_next.ihl         = data_byte[3:0];
            if (count_reg == POS_NH6)      cap_next.nh6         = data_byte;
            if (count_reg == POS_PROTO4)   cap_next.proto4      = data_byte;
            for (int j = 0; j < ADDR_BYTES; j++)
            begin
                if (count_reg == 16'(ADDR_FIRST + j))
                    cap_next.addr[8*(ADDR_BYTES-1-j) +: 8] = data_byte;
            end
            for (int k = 0; k < PORT_BYTES; k++)
            begin
                if (count_reg == {9'd0, off4} + 16'(k))
                    cap_next.port4[8*(PORT_BYTES-1-k) +: 8] = data_byte;
                if (count_reg == POS_PORT6 + 16'(k))
                    cap_next.port6[8*(PORT_BYTES-1-k) +: 8] = data_byte;
            end
        end
    end

    assign count_next = last_byte ? 16'd0 : len_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept && last_byte)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (rec_ready)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cap_reg <= cap_next;
        end
        if (accept && last_byte)
        begin
            rec_reg <= cap_next;
        end
    end

endmodule

[rtl/ehp_decode.sv]
// ---------------------------------------------------------------------------
// ehp_decode: frame classification and result register
// Classifies a frame record, selects addresses and ports, checks the filter.
// ---------------------------------------------------------------------------
module ehp_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  ehp_pkg::frame_rec_t   rec,
    input  ehp_pkg::filter_t      filter,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ehp_pkg::result_t      res
);
    import ehp_pkg::*;

    result_t     res_reg;
    result_t     res_next;
    logic        res_valid_reg;
    logic        is_ip;
    logic        is_v6;
    logic [7:0]  proto;
    logic [16:0] off;
    logic [16:0] need;
    logic [31:0] ports;

    assign rec_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        res_next              = '0;
        res_next.frame_length = rec.len;
        is_ip = 1'b0;
        is_v6 = 1'b0;

        if (rec.len < ETH_LEN)
        begin
            res_next.frame_class = CLS_SHORT;
        end
        else if (rec.etype == ETYPE_IPV4)
        begin
            if (rec.len >= IP4_END)
            begin
                res_next.frame_class        = CLS_IPV4;
                is_ip                       = 1'b1;
                res_next.source_address_low = {32'd0, rec.addr[223:192]};
                res_next.destination_address_low = {32'd0, rec.addr[191:160]};
            end
            else
            begin
                res_next.frame_class = CLS_IPV4_TRNC;
            end
        end
        else if (rec.etype == ETYPE_IPV6)
        begin
            if (rec.len >= IP6_END)
            begin
                res_next.frame_class              = CLS_IPV6;
                is_ip                             = 1'b1;
                is_v6                             = 1'b1;
                res_next.source_address_high      = rec.addr[255:192];
                res_next.source_address_low       = rec.addr[191:128];
                res_next.destination_address_high = rec.addr[127:64];
                res_next.destination_address_low  = rec.addr[63:0];
            end
            else
            begin
                res_next.frame_class = CLS_IPV6_TRNC;
            end
        end
        else
        begin
            res_next.frame_class = CLS_NON_IP;
        end

        proto = is_v6 ? rec.nh6 : rec.proto4;
        off   = is_v6 ? {1'b0, POS_PORT6} : {10'd0, ETH_LEN7 + {1'b0, rec.ihl, 2'b00}};
        ports = is_v6 ? rec.port6 : rec.port4;
        need  = '0;

        if (is_ip)
        begin
            if (proto == PROTO_TCP)
            begin
                res_next.transport_kind = KIND_TCP;
                need                    = TCP_MIN;
            end
            else if (proto == PROTO_UDP)
            begin
                res_next.transport_kind = KIND_UDP;
                need                    = UDP_MIN;
            end
            else
            begin
                res_next.transport_kind = KIND_OTHER;
            end

            if (need != 17'd0 && {1'b0, rec.len} >= off + need)
            begin
                res_next.source_port      = ports[31:16];
                res_next.destination_port = ports[15:0];
                res_next.ports_valid      = 1'b1;
            end

            res_next.filter_match =
                (is_v6 == filter.is_ipv6) &&
                (res_next.source_address_high == filter.src_high) &&
                (res_next.source_address_low == filter.src_low) &&
                (res_next.destination_address_high == filter.dst_high) &&
                (res_next.destination_address_low == filter.dst_low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rec_valid && rec_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/ethernet_ip_header_parser.sv]
// ---------------------------------------------------------------------------
// ethernet_ip_header_parser: Ethernet / IPv4 / IPv6 / TCP / UDP header parser
// Takes one frame byte per item and gives one result item per frame.
// Throughput: one byte item per cycle while the frame record is not held by the decoder.
// After the last byte is accepted, the result reaches m_tvalid through the
// frame record register and then the result register.
// Reset clears the byte count, both valid flags and the filter registers.
// ---------------------------------------------------------------------------
module ethernet_ip_header_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ehp_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [63:0] source_address_high, [127:64] source_address_low,
    // [191:128] destination_address_high, [255:192] destination_address_low,
    // [271:256] source_port, [287:272] destination_port, [288] filter_match,
    // [304:289] frame_length, [311:305] zero
    output logic [ehp_pkg::M_TDATA_W-1:0]    m_tdata,
    // [2:0] frame_class, [4:3] transport_kind, [5] ports_valid
    output logic [ehp_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ehp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data
);
    import ehp_pkg::*;

    filter_t    filter;
    frame_rec_t rec;
    logic       rec_valid;
    logic       rec_ready;
    result_t    res;

    ehp_filter_regs u_filter_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .filter    (filter)
    );

    ehp_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .data_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    ehp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .filter    (filter),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'd0,
                      res.frame_length,
                      res.filter_match,
                      res.destination_port,
                      res.source_port,
                      res.destination_address_low,
                      res.destination_address_high,
                      res.source_address_low,
                      res.source_address_high};

    assign m_tuser = {res.ports_valid, res.transport_kind, res.frame_class};

    // a last byte always yields a frame record
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> rec_valid)
        else $error("frame record missing after last byte");

    // no record appears without a last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!rec_valid && !(s_tvalid && s_tready && s_tlast)) |=> !rec_valid)
        else $error("frame record without last byte");

    // classes other than full IPv4 and IPv6 carry no transport, ports or match
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !(m_tuser[2:0] == CLS_IPV4 || m_tuser[2:0] == CLS_IPV6))
        |-> (m_tuser[5:3] == 3'd0 && !m_tdata[288]))
        else $error("transport fields set on non-IP frame");

    // ports are only valid for TCP or UDP
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[5]) |-> (m_tuser[4:3] == KIND_TCP || m_tuser[4:3] == KIND_UDP))
        else $error("ports valid on non TCP/UDP frame");

endmodule
